>>> rtl/core/digital_clock_controller_macros.svh
// Assertion macros shared by the clock controller RTL.
`ifndef DIGITAL_CLOCK_CONTROLLER_MACROS_SVH
`define DIGITAL_CLOCK_CONTROLLER_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define DCC_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent that must hold in the same cycle as the antecedent.
`define DCC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/core/dcc_pkg.sv
// Shared types, constants and helper functions of the clock controller.
package dcc_pkg;

  typedef enum logic [1:0] {
    EV_NONE,
    EV_SHORT,
    EV_LONG
  } key_ev_t;

  typedef enum logic [1:0] {
    KP_IDLE,
    KP_FIRST,
    KP_HELD,
    KP_LIFT
  } key_phase_t;

  typedef struct packed {
    key_ev_t ev;
    logic    kick;
    logic    exit_ok;
  } key_evt_t;

  typedef struct packed {
    logic set_mode;
    logic saving;
    logic swap_view;
    logic await_release;
  } mode_t;

  typedef struct packed {
    logic [9:0]  ticks_per_second;
    logic [7:0]  long_press_scans;
    logic [15:0] powersave_ticks;
    logic [9:0]  setting_exit_scans;
    logic [6:0]  dot_half_period;
    logic [3:0]  display_divider;
    logic [3:0]  scan_divider;
  } cfg_t;

  typedef struct packed {
    logic [4:0] h;
    logic [5:0] m;
  } hm_t;

  localparam logic [2:0] REG_TICKS_PER_SECOND   = 3'd0;
  localparam logic [2:0] REG_LONG_PRESS_SCANS   = 3'd1;
  localparam logic [2:0] REG_POWERSAVE_TICKS    = 3'd2;
  localparam logic [2:0] REG_SETTING_EXIT_SCANS = 3'd3;
  localparam logic [2:0] REG_DOT_HALF_PERIOD    = 3'd4;
  localparam logic [2:0] REG_DISPLAY_DIVIDER    = 3'd5;
  localparam logic [2:0] REG_SCAN_DIVIDER       = 3'd6;

  localparam cfg_t CFG_RESET = '{
    ticks_per_second:   10'd956,
    long_press_scans:   8'd200,
    powersave_ticks:    16'd3000,
    setting_exit_scans: 10'd500,
    dot_half_period:    7'd100,
    display_divider:    4'd5,
    scan_divider:       4'd10
  };

  localparam logic [9:0] RELEASED_CAP       = 10'd520;
  localparam logic [6:0] MINUTES_PER_HOUR   = 7'd60;
  localparam logic [6:0] SECONDS_PER_MINUTE = 7'd60;
  localparam logic [5:0] HOURS_PER_DAY      = 6'd24;
  localparam logic [7:0] SEG_BLANK          = 8'hff;
  localparam logic [7:0] DP_CLEAR_MASK      = 8'h7f;

  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0: s = 8'hc0;
      4'd1: s = 8'hf9;
      4'd2: s = 8'ha4;
      4'd3: s = 8'hb0;
      4'd4: s = 8'h99;
      4'd5: s = 8'h92;
      4'd6: s = 8'h82;
      4'd7: s = 8'hf8;
      4'd8: s = 8'h80;
      4'd9: s = 8'h90;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

  // Tens digit of a value below 64 by reciprocal multiply.
  function automatic logic [3:0] tens_of(input logic [5:0] v);
    logic [9:0] p;
    p = {4'd0, v} * 10'd13;
    return {1'b0, p[9:7]};
  endfunction

  function automatic logic [3:0] units_of(input logic [5:0] v);
    logic [5:0] t;
    t = {2'd0, tens_of(v)} * 6'd10;
    return 4'(v - t);
  endfunction

  function automatic hm_t bump_minute(input hm_t t);
    hm_t        r;
    logic [6:0] ms;
    logic [5:0] hs;
    ms = {1'b0, t.m} + 7'd1;
    hs = {1'b0, t.h};
    if (ms >= MINUTES_PER_HOUR) begin
      ms = '0;
      hs = hs + 6'd1;
      if (hs >= HOURS_PER_DAY) begin
        hs = '0;
      end
    end
    r.m = ms[5:0];
    r.h = hs[4:0];
    return r;
  endfunction

endpackage

>>> rtl/core/dcc_key.sv
// Key scan divider and debounce state machine producing press events.
module dcc_key
  import dcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic       released,
  input  logic       await_release,
  input  logic [7:0] long_press_scans,
  input  logic [9:0] setting_exit_scans,
  input  logic [3:0] scan_divider,
  output key_evt_t   evt
);

  logic [3:0] scan_div_count, scan_div_count_next;
  key_phase_t key_phase, key_phase_next;
  logic [7:0] hold_count, hold_count_next;
  logic [9:0] released_count, released_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_div_count <= '0;
      key_phase      <= KP_IDLE;
      hold_count     <= '0;
      released_count <= '0;
    end else if (fire) begin
      scan_div_count <= scan_div_count_next;
      key_phase      <= key_phase_next;
      hold_count     <= hold_count_next;
      released_count <= released_count_next;
    end
  end

  always_comb begin
    scan_div_count_next = scan_div_count + 4'd1;
    key_phase_next      = key_phase;
    hold_count_next     = hold_count;
    released_count_next = released_count;
    evt.ev              = EV_NONE;
    evt.kick            = 1'b0;
    if (scan_div_count_next >= scan_divider) begin
      scan_div_count_next = '0;
      if (!await_release) begin
        if (released) begin
          if (released_count < RELEASED_CAP) begin
            released_count_next = released_count + 10'd1;
          end
        end else begin
          released_count_next = '0;
        end
        case (key_phase)
          KP_IDLE: begin
            if (!released) key_phase_next = KP_FIRST;
          end
          KP_FIRST: begin
            if (!released) begin
              key_phase_next = KP_HELD;
              evt.ev         = EV_SHORT;
              evt.kick       = 1'b1;
            end else begin
              key_phase_next = KP_IDLE;
            end
          end
          KP_HELD: begin
            if (!released) begin
              if (hold_count < long_press_scans) begin
                hold_count_next = hold_count + 8'd1;
              end else begin
                evt.ev   = EV_LONG;
                evt.kick = 1'b1;
              end
            end else begin
              key_phase_next = KP_LIFT;
            end
          end
          KP_LIFT: begin
            if (released) begin
              key_phase_next  = KP_IDLE;
              hold_count_next = '0;
            end else begin
              key_phase_next = KP_HELD;
            end
          end
          default: key_phase_next = KP_IDLE;
        endcase
      end
    end
    evt.exit_ok = released_count_next > setting_exit_scans;
  end

endmodule

>>> rtl/core/dcc_time.sv
// Tick prescaler and hours, minutes and seconds counters.
module dcc_time
  import dcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic       bump,
  input  logic [9:0] ticks_per_second,
  output hm_t        hm,
  output logic [5:0] seconds,
  output hm_t        hm_next,
  output logic [5:0] seconds_next
);

  logic [9:0] tick_count, tick_count_next;
  logic [6:0] sec_sum;
  logic       sec_carry;
  hm_t        hm_mid;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      seconds    <= '0;
      hm         <= '0;
    end else if (fire) begin
      tick_count <= tick_count_next;
      seconds    <= seconds_next;
      hm         <= hm_next;
    end
  end

  always_comb begin
    tick_count_next = tick_count + 10'd1;
    sec_sum         = {1'b0, seconds};
    sec_carry       = 1'b0;
    if (tick_count_next >= ticks_per_second) begin
      tick_count_next = '0;
      sec_sum         = sec_sum + 7'd1;
      if (sec_sum >= SECONDS_PER_MINUTE) begin
        sec_sum   = '0;
        sec_carry = 1'b1;
      end
    end
    seconds_next = sec_sum[5:0];
    hm_mid       = sec_carry ? bump_minute(hm) : hm;
    hm_next      = bump ? bump_minute(hm_mid) : hm_mid;
  end

endmodule

>>> rtl/core/dcc_disp.sv
// Digit multiplexer, dot flasher and segment drive of the display.
module dcc_disp
  import dcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  hm_t        hm,
  input  logic [5:0] seconds,
  input  mode_t      mode,
  input  logic [3:0] display_divider,
  input  logic [6:0] dot_half_period,
  output logic [7:0] segment_reg_next,
  output logic [3:0] enable_reg_next
);

  logic [3:0] display_div_count, display_div_count_next;
  logic [1:0] digit_index, digit_index_next;
  logic [7:0] dot_count, dot_count_next;
  logic       dots_visible, dots_visible_next;
  logic [7:0] segment_reg;
  logic [3:0] enable_reg;
  logic [5:0] hi, lo;
  logic [3:0] digit;
  logic [7:0] seg;

  always_ff @(posedge clk) begin
    if (rst) begin
      display_div_count <= '0;
      digit_index       <= '0;
      dot_count         <= '0;
      dots_visible      <= 1'b1;
      segment_reg       <= SEG_BLANK;
      enable_reg        <= '0;
    end else if (fire) begin
      display_div_count <= display_div_count_next;
      digit_index       <= digit_index_next;
      dot_count         <= dot_count_next;
      dots_visible      <= dots_visible_next;
      segment_reg       <= segment_reg_next;
      enable_reg        <= enable_reg_next;
    end
  end

  always_comb begin
    hi = mode.swap_view ? hm.m : {1'b0, hm.h};
    lo = mode.swap_view ? seconds : hm.m;
    case (digit_index)
      2'd0:    digit = units_of(lo);
      2'd1:    digit = tens_of(lo);
      2'd2:    digit = units_of(hi);
      2'd3:    digit = tens_of(hi);
      default: digit = units_of(lo);
    endcase
    seg = seg_of(digit);

    display_div_count_next = display_div_count + 4'd1;
    digit_index_next       = digit_index;
    dot_count_next         = dot_count;
    dots_visible_next      = dots_visible;
    segment_reg_next       = segment_reg;
    enable_reg_next        = enable_reg;
    if (display_div_count_next >= display_divider) begin
      display_div_count_next = '0;
      if (mode.set_mode) begin
        dot_count_next = dot_count + 8'd1;
        if (dot_count_next == {1'b0, dot_half_period}) begin
          dots_visible_next = 1'b0;
        end
        if (dot_count_next == {dot_half_period, 1'b0}) begin
          dot_count_next    = '0;
          dots_visible_next = 1'b1;
        end
      end else begin
        dot_count_next    = '0;
        dots_visible_next = 1'b1;
      end
      enable_reg_next = '0;
      if (!mode.saving) begin
        if (!digit_index[1] && dots_visible_next) begin
          seg = seg & DP_CLEAR_MASK;
        end
        segment_reg_next = seg;
        enable_reg_next  = 4'b0001 << digit_index;
      end
      digit_index_next = digit_index + 2'd1;
    end
  end

endmodule

>>> rtl/core/dcc_ctrl.sv
// Mode control: view swap, set mode, release wait and power-save timer.
module dcc_ctrl
  import dcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  logic        released,
  input  logic        wake,
  input  key_evt_t    evt,
  input  logic [15:0] powersave_ticks,
  output mode_t       mode,
  output mode_t       mode_next,
  output logic        bump
);

  logic [15:0] idle_count, idle_count_next;
  logic        run_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_count <= '0;
      mode       <= '0;
    end else if (fire) begin
      idle_count <= idle_count_next;
      mode       <= mode_next;
    end
  end

  always_comb begin
    mode_next       = mode;
    idle_count_next = idle_count;
    bump            = 1'b0;
    if (evt.kick) begin
      mode_next.saving = 1'b0;
      idle_count_next  = '0;
    end
    if (idle_count_next < powersave_ticks) begin
      idle_count_next = idle_count_next + 16'd1;
    end else if (!mode.set_mode && wake) begin
      mode_next.saving = 1'b1;
      idle_count_next  = '0;
    end
    run_mode = 1'b1;
    if (mode.await_release) begin
      if (released) mode_next.await_release = 1'b0;
      else run_mode = 1'b0;
    end
    if (run_mode) begin
      if (!mode.set_mode) begin
        if (evt.ev == EV_SHORT) begin
          mode_next.swap_view = !mode.swap_view;
        end else if (evt.ev == EV_LONG) begin
          mode_next.set_mode = 1'b1;
          if (!released) mode_next.await_release = 1'b1;
        end
      end else begin
        if (evt.ev != EV_NONE) begin
          mode_next.swap_view = 1'b0;
          bump                = 1'b1;
        end
        if (evt.exit_ok) mode_next.set_mode = 1'b0;
      end
      if (!mode_next.await_release && mode_next.saving && !wake) begin
        mode_next.saving = 1'b0;
        idle_count_next  = '0;
      end
    end
  end

endmodule

>>> rtl/core/digital_clock_controller.sv
// Top level of the digital clock controller: register port, tick stage and result register.
// Each input beat is one 1 ms tick carrying the key level and the wake line; each accepted
// beat yields exactly one result beat with the display drive, the time and the mode flags
// as they stand after that tick. A beat is taken into an input register and worked by short
// logic into the result register, so the block sustains one beat per clock while the result
// side is not stalled; a stall on the result side holds the input register while the result
// waits. Registers lie at byte offsets 4*i in the order ticks_per_second, long_press_scans,
// powersave_ticks, setting_exit_scans, dot_half_period, display_divider, scan_divider; the
// user must write them only while idle, and the block itself does not enforce this.
`include "digital_clock_controller_macros.svh"
module digital_clock_controller
  import dcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        key_released,
  input  logic        wake_line,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  segments,
  output logic [3:0]  digit_enable,
  output logic [4:0]  hours,
  output logic [5:0]  minutes,
  output logic [5:0]  seconds,
  output logic        setting_mode,
  output logic        power_save
);

  cfg_t       cfg;
  logic       stage_valid;
  logic       stage_key;
  logic       stage_wake;
  logic       fire;
  key_evt_t   evt;
  mode_t      mode, mode_next;
  logic       bump;
  hm_t        hm, hm_next;
  logic [5:0] sec_now, sec_next;
  logic [7:0] segment_next;
  logic [3:0] enable_next;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_TICKS_PER_SECOND:   cfg.ticks_per_second   <= pwdata[9:0];
        REG_LONG_PRESS_SCANS:   cfg.long_press_scans   <= pwdata[7:0];
        REG_POWERSAVE_TICKS:    cfg.powersave_ticks    <= pwdata[15:0];
        REG_SETTING_EXIT_SCANS: cfg.setting_exit_scans <= pwdata[9:0];
        REG_DOT_HALF_PERIOD:    cfg.dot_half_period    <= pwdata[6:0];
        REG_DISPLAY_DIVIDER:    cfg.display_divider    <= pwdata[3:0];
        REG_SCAN_DIVIDER:       cfg.scan_divider       <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_TICKS_PER_SECOND:   prdata = {22'd0, cfg.ticks_per_second};
      REG_LONG_PRESS_SCANS:   prdata = {24'd0, cfg.long_press_scans};
      REG_POWERSAVE_TICKS:    prdata = {16'd0, cfg.powersave_ticks};
      REG_SETTING_EXIT_SCANS: prdata = {22'd0, cfg.setting_exit_scans};
      REG_DOT_HALF_PERIOD:    prdata = {25'd0, cfg.dot_half_period};
      REG_DISPLAY_DIVIDER:    prdata = {28'd0, cfg.display_divider};
      REG_SCAN_DIVIDER:       prdata = {28'd0, cfg.scan_divider};
      default:                prdata = '0;
    endcase
  end

  assign fire     = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_key  <= key_released;
      stage_wake <= wake_line;
    end
  end

  dcc_key u_key (
    .clk                (clk),
    .rst                (rst),
    .fire               (fire),
    .released           (stage_key),
    .await_release      (mode.await_release),
    .long_press_scans   (cfg.long_press_scans),
    .setting_exit_scans (cfg.setting_exit_scans),
    .scan_divider       (cfg.scan_divider),
    .evt                (evt)
  );

  dcc_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .fire            (fire),
    .released        (stage_key),
    .wake            (stage_wake),
    .evt             (evt),
    .powersave_ticks (cfg.powersave_ticks),
    .mode            (mode),
    .mode_next       (mode_next),
    .bump            (bump)
  );

  dcc_time u_time (
    .clk              (clk),
    .rst              (rst),
    .fire             (fire),
    .bump             (bump),
    .ticks_per_second (cfg.ticks_per_second),
    .hm               (hm),
    .seconds          (sec_now),
    .hm_next          (hm_next),
    .seconds_next     (sec_next)
  );

  dcc_disp u_disp (
    .clk              (clk),
    .rst              (rst),
    .fire             (fire),
    .hm               (hm),
    .seconds          (sec_now),
    .mode             (mode),
    .display_divider  (cfg.display_divider),
    .dot_half_period  (cfg.dot_half_period),
    .segment_reg_next (segment_next),
    .enable_reg_next  (enable_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      segments     <= segment_next;
      digit_enable <= enable_next;
      hours        <= hm_next.h;
      minutes      <= hm_next.m;
      seconds      <= sec_next;
      setting_mode <= mode_next.set_mode;
      power_save   <= mode_next.saving;
    end
  end

  `DCC_ASSERT_IMP(a_digit_onehot, clk, rst, out_valid, $onehot0(digit_enable), "digit select not one-hot")
  `DCC_ASSERT_IMP(a_time_range, clk, rst, out_valid, (hours <= 5'd23) && (minutes <= 6'd59) && (seconds <= 6'd59), "time out of range")
  `DCC_ASSERT_IMP(a_no_overwrite, clk, rst, out_valid && !out_ready, !fire, "result overwritten while stalled")
  `DCC_ASSERT_ALWAYS(a_await_in_set, clk, rst, !mode.await_release || mode.set_mode, "release wait outside set mode")

endmodule
